>>> rtl/register_alu_instruction_executor_assert.svh
// Assertion macros used by the executor datapath (rae_dp).
// Expects clk and arst_n to be visible where a macro is used.
`ifndef REGISTER_ALU_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_ALU_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rae_pkg.sv
// Shared types and constants for the register ALU instruction executor.
// No dependencies; every RTL module of the block imports it.
package rae_pkg;

	localparam int NUM_REGS_DEF   = 8;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int PROG_DEPTH_DEF = 256;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_ADDI = 4'd1,
		OP_SUB  = 4'd2,
		OP_MUL  = 4'd3,
		OP_DIV  = 4'd4,
		OP_B    = 4'd5,
		OP_BEQ  = 4'd6,
		OP_BNQ  = 4'd7,
		OP_END  = 4'd8,
		OP_LOAD = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_DIV_OVF  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MDU,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic [2:0]         dest_reg;
		logic [2:0]         src_a_reg;
		logic [2:0]         src_b_reg;
		logic signed [31:0] immediate;
		logic [7:0]         target_index;
	} instr_t;

	typedef struct packed {
		logic [7:0]         next_index;
		logic               reg_written;
		logic [2:0]         written_reg;
		logic signed [31:0] written_value;
		logic               branch_taken;
		logic               halted;
		logic [1:0]         error_code;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic decode;
		logic mdu_start;
		logic load_mdu;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_mdu;
		logic mdu_done;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/register_alu_instruction_executor.sv
// Top level of the register ALU instruction executor.
// Depends on rae_pkg, rae_ctrl, rae_dp (which holds rae_mdu).
//
//  channel  | valid        | stall        | payload          | moves
//  ---------+--------------+--------------+------------------+-------------------------
//  instr    | instr_valid  | instr_stall  | instr  (instr_t) | one decoded instruction
//  result   | result_valid | result_stall | result (result_t)| one result per instruction
//
// One instruction at a time: read, execute, commit; the result register is loaded at commit.
// mul and div, unless the divide reports an error, also pass through the shared radix-2
// multiply/divide unit, between execute and commit. instr is free the cycle after commit,
// also while the previous result still waits; result_stall holds the commit only when the
// result register is still full. Reset clears the register file (valid bits), index, halt.
module register_alu_instruction_executor import rae_pkg::*; #(
	parameter int NUM_REGS   = NUM_REGS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	output logic    instr_stall,
	input  instr_t  instr,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rae_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	rae_dp #(
		.NUM_REGS   (NUM_REGS),
		.DATA_WIDTH (DATA_WIDTH),
		.PROG_DEPTH (PROG_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr        (instr),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/rae_mdu.sv
// Shared radix-2 multiply/divide unit: one bit per cycle, DATA_WIDTH steps.
// Depends on rae_pkg for the default width.
module rae_mdu import rae_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  is_div,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DW);
	localparam logic [CW-1:0] LAST = CW'(DW - 1);

	logic          busy_q, done_q, div_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   acc_q;
	logic [DW-1:0] x_q, y_q;

	logic [DW-1:0] mag_a, mag_b, quo_neg;
	logic [DW:0]   shifted, trial, madd;

	always_comb begin
		mag_a   = a[DW-1] ? ('0 - a) : a;
		mag_b   = b[DW-1] ? ('0 - b) : b;
		shifted = {acc_q[DW-1:0], x_q[DW-1]};
		trial   = shifted - {1'b0, y_q};
		madd    = acc_q + {1'b0, x_q};
		quo_neg = '0 - x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[DW-1] ^ b[DW-1];
			acc_q <= '0;
			x_q   <= is_div ? mag_a : a;
			y_q   <= is_div ? mag_b : b;
		end else if (busy_q) begin
			if (div_q) begin
				// restoring step: keep the trial remainder when it did not go negative
				if (!trial[DW]) begin
					acc_q <= trial;
					x_q   <= {x_q[DW-2:0], 1'b1};
				end else begin
					acc_q <= shifted;
					x_q   <= {x_q[DW-2:0], 1'b0};
				end
			end else begin
				if (y_q[0]) begin
					acc_q <= madd;
				end
				x_q <= {x_q[DW-2:0], 1'b0};
				y_q <= {1'b0, y_q[DW-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? quo_neg : x_q) : acc_q[DW-1:0];

endmodule

>>> rtl/rae_ctrl.sv
// Sequencing state machine of the executor.
// Depends on rae_pkg for the state, command and status types.
module rae_ctrl import rae_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	output logic    instr_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (instr_valid) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = sts.need_mdu ? ST_MDU : ST_FINISH;
			end
			ST_MDU: begin
				if (sts.mdu_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		instr_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				instr_stall = 1'b0;
				cmd.capture = instr_valid;
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_EXEC: begin
				cmd.decode    = 1'b1;
				cmd.mdu_start = sts.need_mdu;
			end
			ST_MDU: begin
				cmd.load_mdu = sts.mdu_done;
			end
			ST_FINISH: begin
				// hold until the result register can take the new item
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/rae_dp.sv
// Datapath: instruction register, register file, index and halt state,
// decode, result register. Depends on rae_pkg, rae_mdu and the assertion macro header.
module rae_dp import rae_pkg::*; #(
	parameter int NUM_REGS   = NUM_REGS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  instr_t  instr,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	`include "register_alu_instruction_executor_assert.svh"

	localparam int DW = DATA_WIDTH;
	localparam int RW = $clog2(NUM_REGS);
	localparam int IW = $clog2(PROG_DEPTH);
	localparam logic [5:0]    NREGS6   = 6'(NUM_REGS);
	localparam logic [17:0]   DEPTH18  = 18'(PROG_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(PROG_DEPTH - 1);
	localparam logic [DW-1:0] DMIN     = {1'b1, {(DW-1){1'b0}}};

	// reduce a 3-bit register number modulo the register count
	function automatic logic [RW-1:0] reg_sel(input logic [2:0] x);
		logic [5:0] r;
		r = {3'b000, x};
		for (int k = 0; k < 4; k++) begin
			if (r >= NREGS6) begin
				r = r - NREGS6;
			end
		end
		return r[RW-1:0];
	endfunction

	instr_t        ins_q;
	logic [DW-1:0] rf_mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [DW-1:0] rda_q, rdb_q;
	logic          vla_q, vlb_q;
	logic [IW-1:0] idx_q;
	logic          halt_q;

	logic          res_wr_q, res_taken_q, res_halt_q;
	logic [DW-1:0] res_val_q;
	err_t          res_err_q;
	logic [IW-1:0] res_next_q;

	logic          out_valid_q;
	result_t       result_q;

	logic [RW-1:0] rd_idx, ra_idx, rb_idx, portb_addr;
	logic [DW-1:0] opa, opb, imm_dw, mdu_res;
	logic [DW+31:0] imm_ext;
	logic [17:0]   tgt_r;
	logic [IW-1:0] target_idx, nxt_seq;
	logic          is_cmp, wr_en, mdu_done;

	logic          d_wr, d_taken, d_halt, d_mdu;
	logic [DW-1:0] d_val;
	err_t          d_err;
	logic [IW-1:0] d_next;

	logic [IW+7:0]  nx_ext;
	logic [RW+2:0]  rd_ext;
	logic [DW+31:0] val_ext;

	always_comb begin
		rd_idx     = reg_sel(ins_q.dest_reg);
		ra_idx     = reg_sel(ins_q.src_a_reg);
		rb_idx     = reg_sel(ins_q.src_b_reg);
		is_cmp     = (ins_q.opcode == OP_BEQ) || (ins_q.opcode == OP_BNQ);
		// branches compare dest_reg against src_a_reg
		portb_addr = is_cmp ? rd_idx : rb_idx;
		opa        = vla_q ? rda_q : '0;
		opb        = vlb_q ? rdb_q : '0;
		imm_ext    = {{DW{ins_q.immediate[31]}}, ins_q.immediate};
		imm_dw     = imm_ext[DW-1:0];
		nxt_seq    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	end

	// branch target modulo the program depth, one restoring step per bit
	always_comb begin
		tgt_r = '0;
		for (int i = 7; i >= 0; i--) begin
			tgt_r = {tgt_r[16:0], ins_q.target_index[i]};
			if (tgt_r >= DEPTH18) begin
				tgt_r = tgt_r - DEPTH18;
			end
		end
		target_idx = tgt_r[IW-1:0];
	end

	always_comb begin
		d_wr    = 1'b0;
		d_val   = '0;
		d_taken = 1'b0;
		d_err   = ERR_NONE;
		d_next  = nxt_seq;
		d_halt  = halt_q;
		d_mdu   = 1'b0;
		if (halt_q) begin
			d_next = idx_q;
		end else begin
			case (ins_q.opcode)
				OP_ADD: begin
					d_wr  = 1'b1;
					d_val = opa + opb;
				end
				OP_ADDI: begin
					d_wr  = 1'b1;
					d_val = opa + imm_dw;
				end
				OP_SUB: begin
					d_wr  = 1'b1;
					d_val = opa - opb;
				end
				OP_MUL: begin
					d_wr  = 1'b1;
					d_mdu = 1'b1;
				end
				OP_DIV: begin
					if (opb == '0) begin
						d_err = ERR_DIV_ZERO;
					end else if ((opa == DMIN) && (opb == '1)) begin
						d_err = ERR_DIV_OVF;
					end else begin
						d_wr  = 1'b1;
						d_mdu = 1'b1;
					end
				end
				OP_B: begin
					d_taken = 1'b1;
				end
				OP_BEQ: begin
					d_taken = (opb == opa);
				end
				OP_BNQ: begin
					d_taken = (opb != opa);
				end
				OP_END: begin
					d_halt = 1'b1;
					d_next = idx_q;
				end
				OP_LOAD: begin
					d_wr  = 1'b1;
					d_val = imm_dw;
				end
				default: begin
					d_wr = 1'b0;
				end
			endcase
			if (d_taken) begin
				d_next = target_idx;
			end
		end
	end

	assign wr_en = cmd.commit && res_wr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ins_q <= instr;
		end
		if (cmd.read) begin
			rda_q <= rf_mem_q[ra_idx];
			rdb_q <= rf_mem_q[portb_addr];
			vla_q <= rf_vld_q[ra_idx];
			vlb_q <= rf_vld_q[portb_addr];
		end
		if (wr_en) begin
			rf_mem_q[rd_idx] <= res_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			res_wr_q    <= d_wr;
			res_val_q   <= d_val;
			res_taken_q <= d_taken;
			res_err_q   <= d_err;
			res_next_q  <= d_next;
			res_halt_q  <= d_halt;
		end else if (cmd.load_mdu) begin
			res_val_q <= mdu_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			idx_q    <= '0;
			halt_q   <= 1'b0;
		end else if (cmd.commit) begin
			idx_q  <= res_next_q;
			halt_q <= res_halt_q;
			if (res_wr_q) begin
				rf_vld_q[rd_idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		nx_ext  = {8'h00, res_next_q};
		rd_ext  = {3'b000, rd_idx};
		val_ext = {{32{res_val_q[DW-1]}}, res_val_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.next_index    <= nx_ext[7:0];
			result_q.reg_written   <= res_wr_q;
			result_q.written_reg   <= res_wr_q ? rd_ext[2:0] : 3'b000;
			result_q.written_value <= res_wr_q ? val_ext[31:0] : 32'sd0;
			result_q.branch_taken  <= res_taken_q;
			result_q.halted        <= res_halt_q;
			result_q.error_code    <= res_err_q;
		end
	end

	// advance the result register; a transfer frees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	rae_mdu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mdu_start),
		.is_div (ins_q.opcode == OP_DIV),
		.a      (opa),
		.b      (opb),
		.done   (mdu_done),
		.result (mdu_res)
	);

	assign sts.need_mdu = d_mdu;
	assign sts.mdu_done = mdu_done;
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = result_q;

	`RAE_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_q, "commit did not raise result valid")
	`RAE_ASSERT_IMP(a_wr_no_err, out_valid_q && result_q.reg_written,
		result_q.error_code == ERR_NONE, "register write reported with an error")
	`RAE_ASSERT_IMP(a_halted_quiet, cmd.commit && halt_q, !res_wr_q && !res_taken_q,
		"halted block wrote a register or branched")
	`RAE_ASSERT_IMP(a_mdu_needed, cmd.mdu_start, d_mdu && cmd.decode,
		"multiply/divide started for an instruction that does not need it")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for register_alu_instruction_executor.
// Drives decoded instructions and checks every result against a local executor
// model or a typed-in expectation. Depends on rae_pkg and the executor RTL.
`timescale 1ns / 1ps

module testbench;
	import rae_pkg::*;

	localparam int          RESET_CYCLES   = 7;
	localparam int          RAND_PER_PHASE = 505;
	localparam int          HALTED_ITEMS   = 20;
	localparam int          DRAIN_CYCLES   = 60;
	localparam int          QUIET_LIMIT    = 4000;
	localparam logic [3:0]  OP_SPARE_LO    = 4'd10;
	localparam logic [3:0]  OP_SPARE_HI    = 4'd15;
	localparam logic [31:0] INT_MIN        = 32'h8000_0000;
	localparam logic [31:0] INT_MAX        = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_ONE      = 32'hffff_ffff;

	typedef struct packed {
		instr_t  ins;
		logic    typed;
		result_t want;
	} dir_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    instr_valid  = 1'b0;
	logic    instr_stall;
	instr_t  instr        = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// executor model state
	logic signed [31:0] arch_regs [8];
	logic [7:0]         arch_pc;
	logic               arch_halted;

	result_t  expected_results [$];
	dir_row_t dir_rows [$];
	int       mismatch_cnt = 0;
	int       quiet_cycles = 0;
	int       snd_idle_pct = 0;
	int       rcv_idle_pct = 0;

	register_alu_instruction_executor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic instr_t mk(logic [3:0] op, int rd, int ra, int rb, logic [31:0] imm,
			int tgt);
		instr_t x;
		x.opcode       = op;
		x.dest_reg     = rd[2:0];
		x.src_a_reg    = ra[2:0];
		x.src_b_reg    = rb[2:0];
		x.immediate    = imm;
		x.target_index = tgt[7:0];
		return x;
	endfunction

	function automatic result_t rs(int nxt, logic wr, int rg, logic [31:0] val, logic tk,
			logic hl, err_t err);
		result_t r;
		r.next_index    = nxt[7:0];
		r.reg_written   = wr;
		r.written_reg   = rg[2:0];
		r.written_value = val;
		r.branch_taken  = tk;
		r.halted        = hl;
		r.error_code    = err;
		return r;
	endfunction

	// Execute one instruction on the model state and return its result.
	function automatic result_t exec_instr(instr_t x);
		result_t            r;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] val;
		logic [7:0]         nxt;
		logic               wr;
		logic               taken;
		err_t               err;
		r     = '0;
		a     = arch_regs[x.src_a_reg];
		b     = arch_regs[x.src_b_reg];
		val   = '0;
		nxt   = arch_pc + 8'd1;
		wr    = 1'b0;
		taken = 1'b0;
		err   = ERR_NONE;
		if (arch_halted) begin
			r.next_index = arch_pc;
			r.halted     = 1'b1;
			return r;
		end
		case (x.opcode)
			OP_ADD: begin
				val = a + b;
				wr  = 1'b1;
			end
			OP_ADDI: begin
				val = a + x.immediate;
				wr  = 1'b1;
			end
			OP_SUB: begin
				val = a - b;
				wr  = 1'b1;
			end
			OP_MUL: begin
				val = a * b;
				wr  = 1'b1;
			end
			OP_DIV: begin
				if (b == 0) begin
					err = ERR_DIV_ZERO;
				end else if (a == INT_MIN && b == MINUS_ONE) begin
					err = ERR_DIV_OVF;
				end else begin
					val = a / b;
					wr  = 1'b1;
				end
			end
			OP_B:    taken = 1'b1;
			OP_BEQ:  taken = (arch_regs[x.dest_reg] == a);
			OP_BNQ:  taken = (arch_regs[x.dest_reg] != a);
			OP_END: begin
				arch_halted = 1'b1;
				nxt         = arch_pc;
			end
			OP_LOAD: begin
				val = x.immediate;
				wr  = 1'b1;
			end
			default: ;
		endcase
		if (wr)
			arch_regs[x.dest_reg] = val;
		if (taken)
			nxt = x.target_index;
		arch_pc         = nxt;
		r.next_index    = nxt;
		r.reg_written   = wr;
		r.written_reg   = wr ? x.dest_reg : 3'd0;
		r.written_value = wr ? val : 32'sd0;
		r.branch_taken  = taken;
		r.halted        = arch_halted;
		r.error_code    = err;
		return r;
	endfunction

	function automatic instr_t rand_instr();
		instr_t     x;
		int         pick;
		logic [3:0] op;
		logic [31:0] imm;
		pick = $urandom_range(0, 99);
		if (pick < 12)      op = OP_LOAD;
		else if (pick < 22) op = OP_ADD;
		else if (pick < 32) op = OP_ADDI;
		else if (pick < 42) op = OP_SUB;
		else if (pick < 54) op = OP_MUL;
		else if (pick < 68) op = OP_DIV;
		else if (pick < 74) op = OP_B;
		else if (pick < 83) op = OP_BEQ;
		else if (pick < 93) op = OP_BNQ;
		else                op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		// bias toward values that hit wrap, zero divisors and overflow
		case ($urandom_range(0, 3))
			0: imm = 32'($urandom_range(0, 15)) - 32'd8;
			1: begin
				case ($urandom_range(0, 4))
					0: imm = '0;
					1: imm = MINUS_ONE;
					2: imm = INT_MIN;
					3: imm = INT_MAX;
					default: imm = 32'd1;
				endcase
			end
			default: imm = $urandom;
		endcase
		x = mk(op, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7), imm,
			$urandom_range(0, 255));
		return x;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Append one row to the directed table.
	task automatic add_row(instr_t ins, logic typed, result_t want);
		dir_row_t row;
		row.ins   = ins;
		row.typed = typed;
		row.want  = want;
		dir_rows  = {dir_rows, row};
	endtask

	// Present one instruction, hold it until the transfer, then queue its result.
	task automatic send_instr(instr_t x, logic typed, result_t want);
		result_t pred;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			instr_valid <= 1'b0;
			@(negedge clk);
		end
		instr_valid <= 1'b1;
		instr       <= x;
		@(posedge clk);
		while (instr_stall)
			@(posedge clk);
		pred = exec_instr(x);
		if (typed)
			pred = want;
		expected_results = {expected_results, pred};
		@(negedge clk);
	endtask

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = result;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result next_index 0x%0h",
					got.next_index));
			end else begin
				want = expected_results.pop_front();
				check_field("next_index", got.next_index, want.next_index);
				check_field("reg_written", got.reg_written, want.reg_written);
				check_field("written_reg", got.written_reg, want.written_reg);
				check_field("written_value", got.written_value, want.written_value);
				check_field("branch_taken", got.branch_taken, want.branch_taken);
				check_field("halted", got.halted, want.halted);
				check_field("error_code", got.error_code, want.error_code);
			end
		end
	end

	// Count cycles without any transfer; a hung block ends the run here.
	always @(posedge clk) begin
		if ((instr_valid && !instr_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int k = 0; k < 8; k++)
			arch_regs[k] = '0;
		arch_pc     = '0;
		arch_halted = 1'b0;

		// reset state, extremes and both division errors are typed in
		add_row(mk(OP_ADD, 1, 0, 0, 0, 0), 1'b1,
			rs(1, 1'b1, 1, 0, 1'b0, 1'b0, ERR_NONE));
		add_row(mk(OP_LOAD, 1, 0, 0, INT_MAX, 0), 1'b1,
			rs(2, 1'b1, 1, INT_MAX, 1'b0, 1'b0, ERR_NONE));
		add_row(mk(OP_LOAD, 2, 0, 0, INT_MIN, 0), 1'b1,
			rs(3, 1'b1, 2, INT_MIN, 1'b0, 1'b0, ERR_NONE));
		add_row(mk(OP_LOAD, 3, 7, 7, MINUS_ONE, 255), 1'b1,
			rs(4, 1'b1, 3, MINUS_ONE, 1'b0, 1'b0, ERR_NONE));
		add_row(mk(OP_DIV, 4, 2, 3, 0, 0), 1'b1,
			rs(5, 1'b0, 0, 0, 1'b0, 1'b0, ERR_DIV_OVF));
		add_row(mk(OP_DIV, 4, 1, 0, 0, 0), 1'b1,
			rs(6, 1'b0, 0, 0, 1'b0, 1'b0, ERR_DIV_ZERO));
		add_row(mk(OP_ADD, 5, 1, 1, 0, 0), 1'b0, '0);
		add_row(mk(OP_ADDI, 6, 1, 0, 32'd1, 0), 1'b0, '0);
		add_row(mk(OP_SUB, 7, 2, 1, 0, 0), 1'b0, '0);
		add_row(mk(OP_MUL, 5, 2, 3, 0, 0), 1'b0, '0);
		add_row(mk(OP_MUL, 6, 1, 1, 0, 0), 1'b0, '0);
		add_row(mk(OP_DIV, 7, 1, 3, 0, 0), 1'b0, '0);
		add_row(mk(OP_LOAD, 4, 0, 0, -32'sd7, 0), 1'b0, '0);
		add_row(mk(OP_LOAD, 5, 0, 0, 32'd2, 0), 1'b0, '0);
		add_row(mk(OP_DIV, 6, 4, 5, 0, 0), 1'b0, '0);
		add_row(mk(OP_DIV, 6, 5, 4, 0, 0), 1'b0, '0);
		add_row(mk(OP_B, 0, 0, 0, 0, 255), 1'b1,
			rs(255, 1'b0, 0, 0, 1'b1, 1'b0, ERR_NONE));
		// index wraps from the last slot to zero
		add_row(mk(OP_ADDI, 0, 0, 0, 0, 0), 1'b1,
			rs(0, 1'b1, 0, 0, 1'b0, 1'b0, ERR_NONE));
		add_row(mk(OP_BEQ, 4, 4, 0, 0, 90), 1'b0, '0);
		add_row(mk(OP_BNQ, 4, 5, 0, 0, 128), 1'b0, '0);
		add_row(mk(OP_BEQ, 4, 5, 0, 0, 3), 1'b0, '0);
		add_row(mk(OP_BNQ, 1, 1, 0, 0, 3), 1'b0, '0);
		add_row(mk(OP_SPARE_HI, 7, 7, 7, MINUS_ONE, 255), 1'b0, '0);
		add_row(mk(OP_SPARE_LO, 2, 1, 3, INT_MIN, 17), 1'b0, '0);
		add_row(mk(OP_ADDI, 2, 2, 0, INT_MIN, 0), 1'b0, '0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle_pct = 31;
		rcv_idle_pct = 60;
		foreach (dir_rows[i])
			send_instr(dir_rows[i].ins, dir_rows[i].typed, dir_rows[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 31;
					rcv_idle_pct = 60;
				end
				1: begin
					snd_idle_pct = 60;
					rcv_idle_pct = 31;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++)
				send_instr(rand_instr(), 1'b0, '0);
		end

		// halt, then confirm that later instructions change nothing
		send_instr(mk(OP_END, 0, 0, 0, 0, 0), 1'b0, '0);
		snd_idle_pct = 31;
		rcv_idle_pct = 31;
		for (int n = 0; n < HALTED_ITEMS; n++)
			send_instr(rand_instr(), 1'b0, '0);
		instr_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/rae_pkg.sv
rtl/rae_mdu.sv
rtl/rae_ctrl.sv
rtl/rae_dp.sv
rtl/register_alu_instruction_executor.sv
tb/testbench.sv
